// ===== sv/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg: shared definitions for the fuzzy subsequence scorer
// Register indexes, scoring constants, field widths and character helpers.
// ----------------------------------------------------------------------------
package fss_pkg;

  // Query capacity and derived widths.
  localparam int unsigned MAX_QUERY = 32;
  localparam int unsigned QLEN_W    = 6;
  localparam int unsigned SCORE_W   = 9;
  localparam int unsigned PTS_W     = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CfgQueryLength = 3'd0,
    CfgQueryWord0  = 3'd1,
    CfgQueryWord1  = 3'd2,
    CfgQueryWord2  = 3'd3,
    CfgQueryWord3  = 3'd4
  } cfg_reg_e;

  // Query storage: four words of eight characters, character 0 lowest.
  typedef logic [3:0][7:0][7:0] query_t;

  // Points awarded for a matched query character.
  localparam logic [PTS_W-1:0] PtsTextStart  = 5'd10;
  localparam logic [PTS_W-1:0] PtsFirstQuery = 5'd6;
  localparam logic [PTS_W-1:0] PtsOther      = 5'd1;
  localparam logic [PTS_W-1:0] PtsBoundary   = 5'd4;
  localparam logic [PTS_W-1:0] PtsAdjacent   = 5'd8;

  // Separator characters.
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDash   = 8'h2d;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLParen = 8'h28;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  // ASCII-only case folding to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == ChSpace) || (c == ChDash) || (c == ChUnder) ||
           (c == ChSlash) || (c == ChDot) || (c == ChLParen);
  endfunction

endpackage

// ===== sv/fuzzy_subsequence_scorer.sv =====
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Greedy, case-insensitive subsequence match of a configured query against
// a streamed text, with positional and boundary bonus points.
// ----------------------------------------------------------------------------
// Usage:
//   The query length and characters are written over the cfg channel
//   (index 0 length, indexes 1 to 4 the query words) while the block is idle.
//   Text arrives on the s_axis channel, one byte per beat, with tlast on the
//   final byte. For each text, one result beat leaves on m_axis: the score
//   in tdata and a no-match flag in tuser.
// Timing and throughput:
//   A text byte is captured in an input register and then scored against
//   the match state; the result of a last byte is loaded into the result
//   register when that byte is scored, and m_axis_tvalid is driven from it.
//   One byte is taken every cycle unless a last byte waits on a held result;
//   the state update (position, previous byte, running score) sets that rate.
// Reset:
//   Query length and words clear to zero and the match state rearms for a
//   new text. The state also rearms after every result.
// Stall:
//   While a result waits on m_axis, further bytes are still accepted; only
//   a second last byte holds in the input register until the result leaves.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fss_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fss_pkg::CFG_DW-1:0]       cfg_data_i,
  // Text stream in.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] text_char
  input  logic                             s_axis_tlast,  // last_char
  // Result stream out.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [8:0] match_score, [15:9] zero
  output logic                             m_axis_tuser   // [0] no_match
);

  // Configuration registers.
  logic [fss_pkg::QLEN_W-1:0] qlen_q;
  fss_pkg::query_t            query_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q  <= '0;
      query_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fss_pkg::CfgQueryLength: qlen_q     <= cfg_data_i[fss_pkg::QLEN_W-1:0];
        fss_pkg::CfgQueryWord0:  query_q[0] <= cfg_data_i;
        fss_pkg::CfgQueryWord1:  query_q[1] <= cfg_data_i;
        fss_pkg::CfgQueryWord2:  query_q[2] <= cfg_data_i;
        fss_pkg::CfgQueryWord3:  query_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       advance;
  logic       out_valid_q;

  // The scoring stage moves on unless it holds a last byte and the result
  // register is still occupied by an untaken result.
  assign advance       = in_valid_q &&
                         (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Match state.
  logic [fss_pkg::QLEN_W-1:0]  qpos_q, qpos_d;
  logic                        prev_match_q, prev_match_d;
  logic [7:0]                  prev_char_q, prev_char_d;
  logic                        at_start_q, at_start_d;
  logic [fss_pkg::SCORE_W-1:0] score_q, score_d;

  // Scoring logic for the byte in the input register.
  logic [fss_pkg::QLEN_W-1:0]  eff_len;
  logic [7:0]                  qchar;
  logic                        matched;
  logic [fss_pkg::PTS_W-1:0]   pts;
  logic [fss_pkg::QLEN_W-1:0]  qpos_upd;
  logic [fss_pkg::SCORE_W-1:0] score_upd;
  logic                        res_no_match;
  logic [fss_pkg::SCORE_W-1:0] res_score;

  assign eff_len = (qlen_q > fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY)) ?
                   fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY) : qlen_q;
  assign qchar   = query_q[qpos_q[4:3]][qpos_q[2:0]];
  assign matched = (qpos_q < eff_len) &&
                   (fss_pkg::fold_case(in_char_q) == fss_pkg::fold_case(qchar));

  always_comb begin
    if (at_start_q) begin
      pts = fss_pkg::PtsTextStart;
    end else if (qpos_q == '0) begin
      pts = fss_pkg::PtsFirstQuery;
    end else begin
      pts = fss_pkg::PtsOther;
    end
    if (!at_start_q && (fss_pkg::is_separator(prev_char_q) ||
        (fss_pkg::is_upper(in_char_q) && fss_pkg::is_lower(prev_char_q)))) begin
      pts = pts + fss_pkg::PtsBoundary;
    end
    if (prev_match_q) begin
      pts = pts + fss_pkg::PtsAdjacent;
    end
  end

  assign qpos_upd     = matched ? qpos_q + 1'b1 : qpos_q;
  assign score_upd    = matched ? score_q + fss_pkg::SCORE_W'(pts) : score_q;
  assign res_no_match = qpos_upd < eff_len;
  assign res_score    = res_no_match ? '0 : score_upd;

  // Next state: update on each scored byte, rearm after a last byte.
  always_comb begin
    qpos_d       = qpos_q;
    prev_match_d = prev_match_q;
    prev_char_d  = prev_char_q;
    at_start_d   = at_start_q;
    score_d      = score_q;
    if (advance) begin
      if (in_last_q) begin
        qpos_d       = '0;
        prev_match_d = 1'b0;
        prev_char_d  = '0;
        at_start_d   = 1'b1;
        score_d      = '0;
      end else begin
        qpos_d       = qpos_upd;
        prev_match_d = matched;
        prev_char_d  = in_char_q;
        at_start_d   = 1'b0;
        score_d      = score_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qpos_q       <= '0;
      prev_match_q <= 1'b0;
      prev_char_q  <= '0;
      at_start_q   <= 1'b1;
      score_q      <= '0;
    end else begin
      qpos_q       <= qpos_d;
      prev_match_q <= prev_match_d;
      prev_char_q  <= prev_char_d;
      at_start_q   <= at_start_d;
      score_q      <= score_d;
    end
  end

  // Result register.
  logic                        out_no_match_q;
  logic [fss_pkg::SCORE_W-1:0] out_score_q;
  logic                        load_result;

  assign load_result = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      out_score_q    <= res_score;
      out_no_match_q <= res_no_match;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - fss_pkg::SCORE_W)'(0), out_score_q};
  assign m_axis_tuser  = out_no_match_q;

  // Assertions.
  a_qpos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpos_q <= fss_pkg::QLEN_W'(fss_pkg::MAX_QUERY))
    else $error("query position beyond query capacity");

  a_start_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    at_start_q |-> (qpos_q == '0) && (score_q == '0) && !prev_match_q)
    else $error("text start with leftover match state");

  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_no_match_q) |-> (out_score_q == '0))
    else $error("no-match result with nonzero score");

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a pending result");

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> out_valid_q && at_start_q)
    else $error("last byte did not produce a result and rearm");

endmodule
